>>> rtl/core/multiset_bag_table_core_macros.svh
// Assertion macros shared by the checker of multiset_bag_table_core.
// Depends on nothing; included by the files that hold assertions.
`ifndef MULTISET_BAG_TABLE_CORE_MACROS_SVH
`define MULTISET_BAG_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("multiset_bag_table_core: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MBT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("multiset_bag_table_core: next-cycle check failed");

`endif

>>> rtl/core/mbt_pkg.sv
// Shared types and constants of the multiset bag table.
// Used by the store, the top level and the checker; depends on nothing.
package mbt_pkg;

    localparam int CAPACITY    = 32;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int VAL_W       = 32;
    localparam int OP_W        = 2;
    localparam int STAT_W      = 2;
    localparam int FIELD_CNT_W = 6;
    localparam int M_TDATA_W   = 16;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [VAL_W-1:0] val_t;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_COUNT  = 2'd2,
        OP_CLEAR  = 2'd3
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_NONE = 2'd2
    } status_t;

    // Occupancy field as reported when the store is full.
    localparam logic [FIELD_CNT_W-1:0] OCC_AT_CAPACITY = FIELD_CNT_W'(CAPACITY);

    // Access request from the sequencer to the entry store.
    typedef struct packed {
        logic wr_en;
        idx_t wr_addr;
        val_t wr_data;
        logic rd_en;
        idx_t rd_addr;
    } mem_req_t;

endpackage

>>> rtl/core/multiset_bag_table_core.sv
// Top level of the multiset bag table: sequencer, compare unit and output register.
// Depends on mbt_pkg and mbt_store.
//
// Usage. Requests arrive on the s_ stream: s_tuser carries the opcode (insert,
// remove first match, count matches, clear) and s_tdata the signed 32-bit value.
// Each request yields exactly one result transaction on the m_ stream, whose
// m_tdata holds found, match_count, occupancy and status.
// One request is worked at a time; s_tready is high only while the sequencer
// is idle. Every request first walks the valid entries through the single
// memory read port, one entry per cycle, comparing each with the value. A
// remove that finds its value then shifts the later entries down one place
// per cycle, starting from the entry after the first match.
// The result sits in an output register; a new request is accepted while it
// waits, but the next result is only loaded once the receiver has taken it,
// so a stalled receiver holds the block in its final step without loss.
// Reset (aresetn low at a clock edge) empties the bag and drops any result
// not yet taken; stored values need no clearing because entries beyond the
// occupancy are never read.
module multiset_bag_table_core
    import mbt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [VAL_W-1:0]     s_tdata,   // [31:0] item_value
    input  logic [OP_W-1:0]      s_tuser,   // [1:0] opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [0] found, [6:1] match_count,
                                            // [12:7] occupancy, [14:13] status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    state_t  state_reg, state_next;
    opcode_t op_reg, op_next;
    val_t    val_reg, val_next;
    cnt_t    cnt_reg, cnt_next;
    cnt_t    ptr_reg, ptr_next;
    logic    pend_reg, pend_next;
    idx_t    pend_idx_reg, pend_idx_next;
    cnt_t    match_reg, match_next;
    logic    hit_reg, hit_next;
    idx_t    first_idx_reg, first_idx_next;
    logic    m_valid_reg, m_valid_next;

    logic                   found_reg, found_next;
    logic [FIELD_CNT_W-1:0] mcount_reg, mcount_next;
    logic [FIELD_CNT_W-1:0] occ_reg, occ_next;
    status_t                status_reg, status_next;

    mem_req_t mem_req;
    val_t     rd_data;
    logic     is_match;
    cnt_t     occ_after;

    mbt_store u_store (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // The single shared compare unit: stored entry against the request value.
    assign is_match = (rd_data == val_reg);

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        match_next     = match_reg;
        hit_next       = hit_reg;
        first_idx_next = first_idx_reg;
        m_valid_next   = m_valid_reg;
        found_next     = found_reg;
        mcount_next    = mcount_reg;
        occ_next       = occ_reg;
        status_next    = status_reg;
        occ_after      = cnt_reg;
        mem_req        = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = opcode_t'(s_tuser);
                    val_next   = s_tdata;
                    ptr_next   = '0;
                    pend_next  = 1'b0;
                    match_next = '0;
                    hit_next   = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                // Compare the entry read in the previous cycle.
                if (pend_reg && is_match) begin
                    match_next = match_reg + cnt_t'(1);
                    if (!hit_reg) begin
                        hit_next       = 1'b1;
                        first_idx_next = pend_idx_reg;
                    end
                end
                if (ptr_reg < cnt_reg) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = ptr_reg[IDX_W-1:0];
                    pend_next       = 1'b1;
                    pend_idx_next   = ptr_reg[IDX_W-1:0];
                    ptr_next        = ptr_reg + cnt_t'(1);
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        if (op_reg == OP_REMOVE && match_reg != '0) begin
                            ptr_next   = cnt_t'(first_idx_reg) + cnt_t'(1);
                            state_next = S_SHIFT;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_SHIFT: begin
                // Entry read last cycle moves down one place.
                if (pend_reg) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = pend_idx_reg - idx_t'(1);
                    mem_req.wr_data = rd_data;
                end
                if (ptr_reg < cnt_reg) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = ptr_reg[IDX_W-1:0];
                    pend_next       = 1'b1;
                    pend_idx_next   = ptr_reg[IDX_W-1:0];
                    ptr_next        = ptr_reg + cnt_t'(1);
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    status_next = STAT_OK;
                    found_next  = 1'b0;
                    case (op_reg)
                        OP_INSERT: begin
                            if (cnt_reg == cnt_t'(CAPACITY)) begin
                                status_next = STAT_FULL;
                            end else begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = cnt_reg[IDX_W-1:0];
                                mem_req.wr_data = val_reg;
                                occ_after       = cnt_reg + cnt_t'(1);
                            end
                        end
                        OP_REMOVE: begin
                            if (match_reg == '0) begin
                                status_next = STAT_NONE;
                            end else begin
                                found_next = 1'b1;
                                occ_after  = cnt_reg - cnt_t'(1);
                            end
                        end
                        OP_COUNT: begin
                            found_next = (match_reg != '0);
                        end
                        default: begin
                            occ_after = '0;
                        end
                    endcase
                    cnt_next     = occ_after;
                    mcount_next  = FIELD_CNT_W'(match_reg);
                    occ_next     = FIELD_CNT_W'(occ_after);
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg        <= op_next;
        val_reg       <= val_next;
        ptr_reg       <= ptr_next;
        pend_idx_reg  <= pend_idx_next;
        match_reg     <= match_next;
        hit_reg       <= hit_next;
        first_idx_reg <= first_idx_next;
        found_reg     <= found_next;
        mcount_reg    <= mcount_next;
        occ_reg       <= occ_next;
        status_reg    <= status_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, status_reg, occ_reg, mcount_reg, found_reg};

endmodule

>>> rtl/core/mbt_store.sv
// Entry store of the multiset bag table: one write and one registered read port.
// Depends on mbt_pkg.
module mbt_store
    import mbt_pkg::*;
(
    input  logic     aclk,
    input  mem_req_t req,
    output val_t     rd_data
);

    val_t mem [CAPACITY];
    val_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/mbt_checker.sv
// Port-level checker for multiset_bag_table_core, with its bind statement.
// Depends on mbt_pkg and multiset_bag_table_core_macros.svh.
`include "multiset_bag_table_core_macros.svh"

module mbt_checker
    import mbt_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A request is worked alone: no second transaction right after one.
    `MBT_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // A new result is only produced at the end of a request's work.
    `MBT_ASSERT_NOW(a_result_after_work, aclk, aresetn, $rose(m_tvalid), !$past(s_tready))

    // A rejected insert only happens with the store at capacity.
    `MBT_ASSERT_NOW(a_full_means_capacity, aclk, aresetn,
        m_tvalid && m_tdata[14:13] == STAT_FULL, m_tdata[12:7] == OCC_AT_CAPACITY)

    // A result waits until the receiver takes it.
    `MBT_ASSERT_NXT(a_result_held, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

    // A stalled result keeps its contents.
    `MBT_ASSERT_NXT(a_result_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))

endmodule

bind multiset_bag_table_core mbt_checker u_mbt_checker (.*);
